// File: hw/rtl/mesh_closest_triangle_hit_top_macros.svh
// Assertion macros shared by the checker of the closest-hit block.
`ifndef MESH_CLOSEST_TRIANGLE_HIT_TOP_MACROS_SVH
`define MESH_CLOSEST_TRIANGLE_HIT_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MCTH_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MCTH_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

// A signal is low in the cycle after reset is applied.
`define MCTH_ASSERT_RST(lbl, ck, rn, sig, msg) \
  lbl: assert property (@(posedge ck) (!rn) |=> !(sig)) else $error(msg);

`endif

// File: hw/rtl/mcth_pkg.sv
// Shared types, constants and fixed-point helpers of the closest-hit block.
package mcth_pkg;

  localparam int MAX_TRIANGLES = 64;
  localparam int IDX_W         = $clog2(MAX_TRIANGLES);
  localparam int CNT_W         = 7;
  localparam int DIV_STEPS     = 48;
  localparam int IN_DATA_W     = 296;
  localparam int OUT_DATA_W    = 104;

  localparam logic signed [31:0] Q_ONE  = 32'sd65536;
  localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
  localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

  localparam logic       REQ_LOAD      = 1'b0;
  localparam logic       REQ_CAST      = 1'b1;
  localparam logic [1:0] CORNER_0      = 2'd0;
  localparam logic [1:0] CORNER_1      = 2'd1;
  localparam logic [1:0] CORNER_2      = 2'd2;
  localparam logic       REG_TRI_COUNT = 1'b0;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec3_t;

  // Valid bit and triangle index that travel with each test.
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } tag_t;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN, ST_DONE} seq_st_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] a);
    logic signed [31:0] r;
    if (a > SAT_HI) r = 32'sh7fffffff;
    else if (a < SAT_LO) r = 32'sh80000000;
    else r = a[31:0];
    return r;
  endfunction

  function automatic logic signed [49:0] ext32(input logic signed [31:0] a);
    return {{18{a[31]}}, a};
  endfunction

  function automatic logic signed [49:0] ext48(input logic signed [47:0] a);
    return {{2{a[47]}}, a};
  endfunction

  // Full product, shifted right by 16 with floor rounding.
  function automatic logic signed [47:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:16];
  endfunction

  function automatic vec3_t vsub(input vec3_t a, input vec3_t b);
    vec3_t r;
    r.x = sat32(ext32(a.x) - ext32(b.x));
    r.y = sat32(ext32(a.y) - ext32(b.y));
    r.z = sat32(ext32(a.z) - ext32(b.z));
    return r;
  endfunction

  function automatic logic signed [31:0] sub48(input logic signed [47:0] a,
                                               input logic signed [47:0] b);
    return sat32(ext48(a) - ext48(b));
  endfunction

  function automatic logic signed [31:0] add48(input logic signed [47:0] a,
                                               input logic signed [47:0] b,
                                               input logic signed [47:0] c);
    return sat32(ext48(a) + ext48(b) + ext48(c));
  endfunction

endpackage

// File: hw/rtl/mesh_closest_triangle_hit_top.sv
// Nearest ray/triangle hit over a stored mesh of up to 64 triangles.
//
// Input stream: in_tuser selects the transaction kind. A load writes one
// vertex of one triangle and finishes in the cycle it is accepted. A cast
// carries a ray and yields exactly one result transaction on the output
// stream: hit flag in out_tuser, triangle index, t, u and v in out_tdata.
// The APB register triangle_count (offset 0) sets how many triangles each
// cast tests; write it only while the block is idle.
// A cast is tested against one triangle per cycle through a pipeline of a
// vertex read, five geometry stages, a 50-stage divider and a selection
// stage. The next transaction is accepted once the result of the cast has
// been moved to the output register. Of the latency, the divider pipeline
// depth sets the largest share of the part that does not grow with
// triangle_count, the single vertex read port the part that does.
// Reset (rst_n low, synchronous) clears the register, the sequencer and
// the output valid; vertex memory holds garbage until loaded. If the
// receiver stalls, the result waits in the output register while a new
// transaction is accepted; a finished cast then holds its result until
// the output register frees up.
module mesh_closest_triangle_hit_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: tri_slot, corner, vert_x, vert_y, vert_z,
  // org_x, org_y, org_z, dir_x, dir_y, dir_z.
  input  logic [mcth_pkg::IN_DATA_W-1:0]   in_tdata,
  // Fields from bit 0: req_type.
  input  logic [0:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // Fields from bit 0: hit_triangle, hit_distance, hit_u, hit_v, zero pad.
  output logic [mcth_pkg::OUT_DATA_W-1:0]  out_tdata,
  // Fields from bit 0: hit_found.
  output logic [0:0]                       out_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import mcth_pkg::*;

  // Input field unpacking.
  logic [5:0] f_slot;
  logic [1:0] f_corner;
  vec3_t      f_vert, f_org, f_dir;

  assign f_slot   = in_tdata[5:0];
  assign f_corner = in_tdata[7:6];
  assign f_vert   = '{x: in_tdata[39:8],    y: in_tdata[71:40],   z: in_tdata[103:72]};
  assign f_org    = '{x: in_tdata[135:104], y: in_tdata[167:136], z: in_tdata[199:168]};
  assign f_dir    = '{x: in_tdata[231:200], y: in_tdata[263:232], z: in_tdata[295:264]};

  logic in_acc, load_acc, cast_acc;
  assign in_acc   = in_tvalid && in_tready;
  assign load_acc = in_acc && (in_tuser[0] == REQ_LOAD);
  assign cast_acc = in_acc && (in_tuser[0] == REQ_CAST);

  // Configuration register.
  logic [CNT_W-1:0] tri_count_r;
  logic             cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TRI_COUNT);
  assign prdata = {{(32-CNT_W){1'b0}}, tri_count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tri_count_r <= '0;
    end else if (cfg_wr) begin
      tri_count_r <= pwdata[CNT_W-1:0];
    end
  end

  logic [CNT_W-1:0] eff_cnt;
  assign eff_cnt = (tri_count_r > CNT_W'(MAX_TRIANGLES)) ? CNT_W'(MAX_TRIANGLES)
                                                          : tri_count_r;

  // Vertex memories, one per corner, one row per triangle.
  vec3_t mem_c0 [MAX_TRIANGLES];
  vec3_t mem_c1 [MAX_TRIANGLES];
  vec3_t mem_c2 [MAX_TRIANGLES];
  logic  slot_ok;
  assign slot_ok = (int'(f_slot) < MAX_TRIANGLES);

  always_ff @(posedge clk) begin
    if (load_acc && slot_ok) begin
      case (f_corner)
        CORNER_0: mem_c0[IDX_W'(f_slot)] <= f_vert;
        CORNER_1: mem_c1[IDX_W'(f_slot)] <= f_vert;
        CORNER_2: mem_c2[IDX_W'(f_slot)] <= f_vert;
        default: ;
      endcase
    end
  end

  // Sequencer state.
  seq_st_t          st_r, st_nxt;
  logic [CNT_W-1:0] k_r, k_nxt, cnt_r, cnt_nxt, pend_r;
  logic             rd_en, out_load;
  logic             out_tvalid_r;
  vec3_t            org_r, dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      k_r   <= '0;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      k_r   <= k_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    in_tready = (st_r == ST_IDLE);
    case (st_r)
      ST_IDLE: begin
        if (cast_acc) begin
          cnt_nxt = eff_cnt;
          k_nxt   = '0;
          st_nxt  = (eff_cnt == '0) ? ST_DONE : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        rd_en = 1'b1;
        k_nxt = k_r + 1'b1;
        if (k_r == cnt_r - 1'b1) st_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (pend_r == '0) st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Ray held for the whole cast.
  always_ff @(posedge clk) begin
    if (cast_acc) begin
      org_r <= f_org;
      dir_r <= f_dir;
    end
  end

  // Registered vertex read.
  vec3_t rd0_r, rd1_r, rd2_r;
  tag_t  rd_tag_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd0_r <= mem_c0[k_r[IDX_W-1:0]];
      rd1_r <= mem_c1[k_r[IDX_W-1:0]];
      rd2_r <= mem_c2[k_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r.vld <= 1'b0;
    end else begin
      rd_tag_r.vld <= rd_en;
      rd_tag_r.idx <= k_r[IDX_W-1:0];
    end
  end

  // Geometry and division pipelines.
  tag_t               geo_tag, div_tag;
  logic signed [31:0] det, unum, vnum, tnum;
  logic               den_zero;
  logic [2:0][31:0]   quo;

  mcth_tri_test u_geo (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (rd_tag_r),
    .p0      (rd0_r),
    .p1      (rd1_r),
    .p2      (rd2_r),
    .org     (org_r),
    .dir     (dir_r),
    .out_tag (geo_tag),
    .det     (det),
    .unum    (unum),
    .vnum    (vnum),
    .tnum    (tnum)
  );

  mcth_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (geo_tag),
    .den      (det),
    .num      ({tnum, vnum, unum}),
    .out_tag  (div_tag),
    .den_zero (den_zero),
    .quo      (quo)
  );

  // Hit test and nearest selection; results arrive in index order.
  logic signed [31:0] q_u, q_v, q_t;
  logic signed [32:0] uv_sum;
  logic               hit, better;
  logic               best_found_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic signed [31:0] best_t_r, best_u_r, best_v_r;

  assign q_u    = quo[0];
  assign q_v    = quo[1];
  assign q_t    = quo[2];
  assign uv_sum = {q_u[31], q_u} + {q_v[31], q_v};
  assign hit    = !den_zero && (q_u >= 32'sd0) && (q_u <= Q_ONE) && (q_v >= 32'sd0)
                  && (uv_sum <= 33'sd65536) && (q_t > 32'sd0);
  assign better = div_tag.vld && hit && (!best_found_r || (q_t < best_t_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= '0;
      best_found_r <= 1'b0;
    end else if (cast_acc) begin
      pend_r       <= eff_cnt;
      best_found_r <= 1'b0;
    end else begin
      if (div_tag.vld) pend_r <= pend_r - 1'b1;
      if (better) best_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cast_acc) begin
      best_idx_r <= '0;
      best_t_r   <= '0;
      best_u_r   <= '0;
      best_v_r   <= '0;
    end else if (better) begin
      best_idx_r <= div_tag.idx;
      best_t_r   <= q_t;
      best_u_r   <= q_u;
      best_v_r   <= q_v;
    end
  end

  // Output register.
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {2'b00, best_v_r, best_u_r, best_t_r, 6'(best_idx_r)};
      out_tuser_r <= best_found_r;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

endmodule

// File: hw/rtl/mcth_tri_test.sv
// Five-stage geometry pipeline: edges, cross products, determinant and numerators.
module mcth_tri_test (
  input  logic               clk,
  input  logic               rst_n,
  input  mcth_pkg::tag_t     in_tag,
  input  mcth_pkg::vec3_t    p0,
  input  mcth_pkg::vec3_t    p1,
  input  mcth_pkg::vec3_t    p2,
  input  mcth_pkg::vec3_t    org,
  input  mcth_pkg::vec3_t    dir,
  output mcth_pkg::tag_t     out_tag,
  output logic signed [31:0] det,
  output logic signed [31:0] unum,
  output logic signed [31:0] vnum,
  output logic signed [31:0] tnum
);
  import mcth_pkg::*;

  tag_t  s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r, s5_tag_r;
  vec3_t e1_r, e2_r, tv_r;
  vec3_t e1_s2_r, e2_s2_r, tv_s2_r;
  vec3_t e1_s3_r, e2_s3_r, tv_s3_r;
  logic signed [47:0] pp_r [12];
  vec3_t pv_r, qv_r;
  logic signed [47:0] dp_r [12];
  logic signed [31:0] det_r, unum_r, vnum_r, tnum_r;

  // Valid bits move with the data; the pipeline never stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r.vld <= 1'b0;
      s2_tag_r.vld <= 1'b0;
      s3_tag_r.vld <= 1'b0;
      s4_tag_r.vld <= 1'b0;
      s5_tag_r.vld <= 1'b0;
    end else begin
      s1_tag_r <= in_tag;
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
      s4_tag_r <= s3_tag_r;
      s5_tag_r <= s4_tag_r;
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    // Stage 1: edge vectors and origin offset.
    e1_r <= vsub(p1, p0);
    e2_r <= vsub(p2, p0);
    tv_r <= vsub(org, p0);
    // Stage 2: partial products of dir x e2 and tv x e1.
    pp_r[0]  <= mulq(dir.y, e2_r.z);
    pp_r[1]  <= mulq(dir.z, e2_r.y);
    pp_r[2]  <= mulq(dir.z, e2_r.x);
    pp_r[3]  <= mulq(dir.x, e2_r.z);
    pp_r[4]  <= mulq(dir.x, e2_r.y);
    pp_r[5]  <= mulq(dir.y, e2_r.x);
    pp_r[6]  <= mulq(tv_r.y, e1_r.z);
    pp_r[7]  <= mulq(tv_r.z, e1_r.y);
    pp_r[8]  <= mulq(tv_r.z, e1_r.x);
    pp_r[9]  <= mulq(tv_r.x, e1_r.z);
    pp_r[10] <= mulq(tv_r.x, e1_r.y);
    pp_r[11] <= mulq(tv_r.y, e1_r.x);
    e1_s2_r <= e1_r;
    e2_s2_r <= e2_r;
    tv_s2_r <= tv_r;
    // Stage 3: cross product components.
    pv_r.x <= sub48(pp_r[0], pp_r[1]);
    pv_r.y <= sub48(pp_r[2], pp_r[3]);
    pv_r.z <= sub48(pp_r[4], pp_r[5]);
    qv_r.x <= sub48(pp_r[6], pp_r[7]);
    qv_r.y <= sub48(pp_r[8], pp_r[9]);
    qv_r.z <= sub48(pp_r[10], pp_r[11]);
    e1_s3_r <= e1_s2_r;
    e2_s3_r <= e2_s2_r;
    tv_s3_r <= tv_s2_r;
    // Stage 4: dot product terms.
    dp_r[0]  <= mulq(e1_s3_r.x, pv_r.x);
    dp_r[1]  <= mulq(e1_s3_r.y, pv_r.y);
    dp_r[2]  <= mulq(e1_s3_r.z, pv_r.z);
    dp_r[3]  <= mulq(tv_s3_r.x, pv_r.x);
    dp_r[4]  <= mulq(tv_s3_r.y, pv_r.y);
    dp_r[5]  <= mulq(tv_s3_r.z, pv_r.z);
    dp_r[6]  <= mulq(dir.x, qv_r.x);
    dp_r[7]  <= mulq(dir.y, qv_r.y);
    dp_r[8]  <= mulq(dir.z, qv_r.z);
    dp_r[9]  <= mulq(e2_s3_r.x, qv_r.x);
    dp_r[10] <= mulq(e2_s3_r.y, qv_r.y);
    dp_r[11] <= mulq(e2_s3_r.z, qv_r.z);
    // Stage 5: saturated dot products.
    det_r  <= add48(dp_r[0], dp_r[1], dp_r[2]);
    unum_r <= add48(dp_r[3], dp_r[4], dp_r[5]);
    vnum_r <= add48(dp_r[6], dp_r[7], dp_r[8]);
    tnum_r <= add48(dp_r[9], dp_r[10], dp_r[11]);
  end

  assign out_tag = s5_tag_r;
  assign det     = det_r;
  assign unum    = unum_r;
  assign vnum    = vnum_r;
  assign tnum    = tnum_r;

endmodule

// File: hw/rtl/mcth_div.sv
// Pipelined restoring divider: three Q16.16 quotients over one shared divisor.
module mcth_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mcth_pkg::tag_t    in_tag,
  input  logic signed [31:0] den,
  input  logic [2:0][31:0]  num,
  output mcth_pkg::tag_t    out_tag,
  output logic              den_zero,
  output logic [2:0][31:0]  quo
);
  import mcth_pkg::*;

  typedef struct packed {
    tag_t             tag;
    logic             dz;
    logic [31:0]      dmag;
    logic [2:0]       neg;
    logic [2:0][31:0] rem;
    logic [2:0][47:0] dvd;
  } dstage_t;

  dstage_t          st_r [DIV_STEPS+1];
  dstage_t          st0_nxt;
  tag_t             out_tag_r;
  logic             dz_r;
  logic [2:0][31:0] quo_r;
  logic [2:0][31:0] quo_nxt;

  // Entry stage: split into sign and magnitude, dividend is numerator << 16.
  always_comb begin
    st0_nxt      = '0;
    st0_nxt.tag  = in_tag;
    st0_nxt.dz   = (den == 32'sd0);
    st0_nxt.dmag = den[31] ? (32'd0 - den) : den;
    for (int j = 0; j < 3; j++) begin
      st0_nxt.neg[j] = num[j][31] ^ den[31];
      st0_nxt.rem[j] = '0;
      st0_nxt.dvd[j] = {(num[j][31] ? (32'd0 - num[j]) : num[j]), 16'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].tag.vld <= 1'b0;
    end else begin
      st_r[0] <= st0_nxt;
    end
  end

  // One quotient bit per stage and lane.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    dstage_t     nxt;
    logic [32:0] sh;
    logic        ge;

    always_comb begin
      nxt = st_r[i];
      sh  = '0;
      ge  = 1'b0;
      for (int j = 0; j < 3; j++) begin
        sh = {st_r[i].rem[j], st_r[i].dvd[j][47]};
        ge = (sh >= {1'b0, st_r[i].dmag});
        nxt.rem[j] = ge ? 32'(sh - {1'b0, st_r[i].dmag}) : sh[31:0];
        nxt.dvd[j] = {st_r[i].dvd[j][46:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[i+1].tag.vld <= 1'b0;
      end else begin
        st_r[i+1] <= nxt;
      end
    end
  end

  // Apply sign, truncate toward zero and saturate to 32 bits.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (st_r[DIV_STEPS].neg[j]) begin
        if (st_r[DIV_STEPS].dvd[j] > 48'h0000_8000_0000) quo_nxt[j] = 32'h8000_0000;
        else quo_nxt[j] = 32'(48'd0 - st_r[DIV_STEPS].dvd[j]);
      end else begin
        if (st_r[DIV_STEPS].dvd[j] > 48'h0000_7fff_ffff) quo_nxt[j] = 32'h7fff_ffff;
        else quo_nxt[j] = st_r[DIV_STEPS].dvd[j][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tag_r.vld <= 1'b0;
    end else begin
      out_tag_r <= st_r[DIV_STEPS].tag;
    end
  end

  always_ff @(posedge clk) begin
    dz_r  <= st_r[DIV_STEPS].dz;
    quo_r <= quo_nxt;
  end

  assign out_tag  = out_tag_r;
  assign den_zero = dz_r;
  assign quo      = quo_r;

endmodule

// File: hw/rtl/mcth_checker.sv
// Port-level checks of the closest-hit block, bound to the top level.
`include "mesh_closest_triangle_hit_top_macros.svh"

module mcth_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mcth_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]                      out_tuser
);
  import mcth_pkg::*;

  // No result is offered right after reset.
  `MCTH_ASSERT_RST(a_rst_quiet, clk, rst_n, out_tvalid, "result valid after reset")

  // A stalled result keeps its contents.
  `MCTH_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // A miss reports all fields as zero.
  `MCTH_ASSERT_NOW(a_miss_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == '0, "miss carries nonzero fields")

  // A hit has positive distance, u within [0, 1] and non-negative v.
  `MCTH_ASSERT_NOW(a_hit_range, clk, rst_n, out_tvalid && out_tuser[0], ($signed(out_tdata[37:6]) > 32'sd0) && ($signed(out_tdata[69:38]) >= 32'sd0) && ($signed(out_tdata[69:38]) <= Q_ONE) && ($signed(out_tdata[101:70]) >= 32'sd0), "hit out of range")

endmodule

bind mesh_closest_triangle_hit_top mcth_checker u_mcth_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
